@@ rtl/core/dhds_pkg.sv @@
package dhds_pkg;

    localparam int MAX_RAW_WIDTH = 1024;
    localparam int ADDR_W        = $clog2(MAX_RAW_WIDTH);
    localparam int COL_W         = $clog2(MAX_RAW_WIDTH + 1);
    localparam int CFGW_W        = 11;
    localparam int CW_W          = (COL_W > CFGW_W) ? COL_W : CFGW_W;
    localparam int ROW_W         = 13;
    localparam int CMP_W         = (ADDR_W > ROW_W) ? ADDR_W : ROW_W;
    localparam int DEPTH_W       = 16;
    localparam int SUM_W         = DEPTH_W + 2;
    localparam int DEC_W         = 4;
    localparam int OUT_W         = 10;
    localparam int RECIP_SHIFT   = 20;
    localparam int RECIP_W       = 21;
    localparam int STEP_W        = $clog2(DEPTH_W);

    localparam logic [ROW_W-1:0] RAW_ROW_MAX = {ROW_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX     = OUT_W'(512);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_DIVISOR = 3'd4;

    typedef struct packed {
        logic [15:0] depth_sample;
        logic        frame_start;
    } in_item_t;

    typedef struct packed {
        logic [8:0] out_col;
        logic [8:0] out_row;
        logic [7:0] high_byte;
        logic [7:0] low_byte;
        logic       frame_done;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_QUOT,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic quot;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic produce;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // ceil(2^20 / d); exact floor division for the operand ranges used here
    function automatic logic [RECIP_W-1:0] recip(input logic [DEC_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd2:    r = 21'd524288;
            4'd3:    r = 21'd349526;
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209716;
            4'd6:    r = 21'd174763;
            4'd7:    r = 21'd149797;
            4'd8:    r = 21'd131072;
            4'd9:    r = 21'd116509;
            4'd10:   r = 21'd104858;
            4'd11:   r = 21'd95326;
            4'd12:   r = 21'd87382;
            4'd13:   r = 21'd80660;
            4'd14:   r = 21'd74899;
            4'd15:   r = 21'd69906;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/depth_hole_aware_downsample_unit.sv @@
// A new sample is taken only after the last has passed the fetch, quotient and check
// states; one that yields a pixel also waits on the 16-step serial divider and then
// on a free output register.
// A finished pixel waits in the output register while the next sample is taken.
// Reset (aresetn, synchronous): registers to defaults, position and neighbors cleared;
// the line store is not cleared.
module depth_hole_aware_downsample_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dhds_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dhds_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dhds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data
);
    import dhds_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dhds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dhds_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ rtl/core/dhds_divider.sv @@
module dhds_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dhds_pkg::DEPTH_W-1:0] dividend,
    input  logic [dhds_pkg::DEPTH_W-1:0] divisor,
    output logic                         done,
    output logic [dhds_pkg::DEPTH_W-1:0] quotient
);
    import dhds_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DEPTH_W-1:0]  rem_reg;
    logic [DEPTH_W-1:0]  quo_reg;
    logic [DEPTH_W-1:0]  den_reg;
    logic [DEPTH_W:0]    shifted;
    logic                fits;
    logic [DEPTH_W-1:0]  rem_next;
    logic [DEPTH_W-1:0]  quo_next;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted  = {rem_reg, quo_reg[DEPTH_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? DEPTH_W'(shifted - {1'b0, den_reg}) : shifted[DEPTH_W-1:0];
        quo_next = {quo_reg[DEPTH_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DEPTH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/dhds_datapath.sv @@
module dhds_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dhds_pkg::ctrl_cmd_t               cmd,
    output dhds_pkg::dp_status_t              status,
    input  dhds_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dhds_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);
    import dhds_pkg::*;

    // configuration
    logic [CFGW_W-1:0]  raw_width_reg;
    logic [DEC_W-1:0]   decimation_reg;
    logic [OUT_W-1:0]   out_width_reg;
    logic [OUT_W-1:0]   out_height_reg;
    logic [DEPTH_W-1:0] depth_divisor_reg;

    // stream position and neighborhood
    logic [COL_W-1:0]   raw_col_reg;
    logic [ROW_W-1:0]   raw_row_reg;
    logic [DEPTH_W-1:0] prior_sample_reg;
    logic [DEPTH_W-1:0] prior_row_above_reg;
    logic [DEPTH_W-1:0] row_store [MAX_RAW_WIDTH];
    logic [DEPTH_W-1:0] above_rd_reg;

    // per-transaction working registers
    logic [ADDR_W-1:0]  c_reg;
    logic [ROW_W-1:0]   r_reg;
    logic [DEPTH_W-1:0] sample_reg;
    logic [DEPTH_W-1:0] win0_reg;
    logic [DEPTH_W-1:0] win2_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [2:0]         cnt_reg;
    logic [ADDR_W+RECIP_W-1:0] xprod_reg;
    logic [ROW_W+RECIP_W-1:0]  yprod_reg;
    logic [ADDR_W-1:0]  x_reg;
    logic [ROW_W-1:0]   y_reg;
    logic [DEPTH_W-1:0] avg_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [CW_W-1:0]    width_eff;
    logic [DEC_W-1:0]   dec_eff;
    logic [OUT_W-1:0]   ow_eff;
    logic [OUT_W-1:0]   oh_eff;
    logic [DEPTH_W-1:0] div_eff;
    logic [COL_W-1:0]   col_base;
    logic [ROW_W-1:0]   row_base;
    logic               wrap;
    logic [ADDR_W-1:0]  c_cur;
    logic [ROW_W-1:0]   r_cur;
    logic [ADDR_W-1:0]  cc;
    logic [ROW_W-1:0]   rr;
    logic [RECIP_W-1:0] rcp;
    logic [SUM_W-1:0]   sum_w;
    logic [2:0]         cnt_w;
    logic [SUM_W+RECIP_W-1:0] third;
    logic [DEPTH_W-1:0] avg_w;
    logic [ADDR_W+DEC_W-1:0] xd;
    logic [ROW_W+DEC_W-1:0]  yd;
    logic [CMP_W-1:0]   x_ext;
    logic [CMP_W-1:0]   y_ext;
    logic [CMP_W-1:0]   ow_ext;
    logic [CMP_W-1:0]   oh_ext;
    logic               in_range;
    logic               last_pix;
    logic               div_done;
    logic [DEPTH_W-1:0] div_quo;

    always_comb begin
        if (raw_width_reg < CFGW_W'(2)) begin
            width_eff = CW_W'(2);
        end else if (CW_W'(raw_width_reg) > CW_W'(MAX_RAW_WIDTH)) begin
            width_eff = CW_W'(MAX_RAW_WIDTH);
        end else begin
            width_eff = CW_W'(raw_width_reg);
        end
        dec_eff = (decimation_reg == '0) ? DEC_W'(1) : decimation_reg;
        ow_eff  = (out_width_reg > OUT_MAX) ? OUT_MAX : out_width_reg;
        oh_eff  = (out_height_reg > OUT_MAX) ? OUT_MAX : out_height_reg;
        div_eff = (depth_divisor_reg == '0) ? DEPTH_W'(1) : depth_divisor_reg;
        rcp     = recip(dec_eff);
    end

    // position of the incoming sample
    always_comb begin
        col_base = s_data.frame_start ? '0 : raw_col_reg;
        row_base = s_data.frame_start ? '0 : raw_row_reg;
        wrap     = CW_W'(col_base) >= width_eff;
        c_cur    = wrap ? '0 : col_base[ADDR_W-1:0];
        if (wrap && row_base < RAW_ROW_MAX) begin
            r_cur = row_base + ROW_W'(1);
        end else begin
            r_cur = row_base;
        end
    end

    assign cc = c_reg - ADDR_W'(1);
    assign rr = r_reg - ROW_W'(1);

    // masked sum of the 2x2 window
    always_comb begin
        sum_w = '0;
        cnt_w = '0;
        if (win0_reg != '0) begin
            sum_w = sum_w + SUM_W'(win0_reg);
            cnt_w = cnt_w + 3'd1;
        end
        if (above_rd_reg != '0) begin
            sum_w = sum_w + SUM_W'(above_rd_reg);
            cnt_w = cnt_w + 3'd1;
        end
        if (win2_reg != '0) begin
            sum_w = sum_w + SUM_W'(win2_reg);
            cnt_w = cnt_w + 3'd1;
        end
        if (sample_reg != '0) begin
            sum_w = sum_w + SUM_W'(sample_reg);
            cnt_w = cnt_w + 3'd1;
        end
    end

    always_comb begin
        third = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(recip(DEC_W'(3)));
        case (cnt_reg)
            3'd1:    avg_w = sum_reg[DEPTH_W-1:0];
            3'd2:    avg_w = sum_reg[DEPTH_W:1];
            3'd3:    avg_w = third[RECIP_SHIFT +: DEPTH_W];
            3'd4:    avg_w = sum_reg[DEPTH_W+1:2];
            default: avg_w = '0;
        endcase
    end

    // window corner test and output bounds
    always_comb begin
        xd       = (ADDR_W+DEC_W)'(x_reg) * (ADDR_W+DEC_W)'(dec_eff);
        yd       = (ROW_W+DEC_W)'(y_reg) * (ROW_W+DEC_W)'(dec_eff);
        x_ext    = CMP_W'(x_reg);
        y_ext    = CMP_W'(y_reg);
        ow_ext   = CMP_W'(ow_eff);
        oh_ext   = CMP_W'(oh_eff);
        in_range = (ow_eff >= OUT_W'(2)) && (oh_eff >= OUT_W'(2))
                   && (x_ext < ow_ext - CMP_W'(1)) && (y_ext < oh_ext - CMP_W'(1));
        last_pix = (x_ext == ow_ext - CMP_W'(2)) && (y_ext == oh_ext - CMP_W'(2));
        status.produce = (c_reg != '0) && (r_reg != '0)
                         && (xd == (ADDR_W+DEC_W)'(cc)) && (yd == (ROW_W+DEC_W)'(rr))
                         && in_range;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_width_reg     <= CFGW_W'(640);
            decimation_reg    <= DEC_W'(2);
            out_width_reg     <= OUT_W'(320);
            out_height_reg    <= OUT_W'(240);
            depth_divisor_reg <= DEPTH_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RAW_WIDTH:     raw_width_reg     <= cfg_data[CFGW_W-1:0];
                CFG_DECIMATION:    decimation_reg    <= cfg_data[DEC_W-1:0];
                CFG_OUT_WIDTH:     out_width_reg     <= cfg_data[OUT_W-1:0];
                CFG_OUT_HEIGHT:    out_height_reg    <= cfg_data[OUT_W-1:0];
                CFG_DEPTH_DIVISOR: depth_divisor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_col_reg         <= '0;
            raw_row_reg         <= '0;
            prior_sample_reg    <= '0;
            prior_row_above_reg <= '0;
        end else begin
            if (cmd.accept) begin
                raw_col_reg      <= COL_W'(c_cur) + COL_W'(1);
                raw_row_reg      <= r_cur;
                prior_sample_reg <= s_data.depth_sample;
            end
            if (cmd.fetch) begin
                prior_row_above_reg <= above_rd_reg;
            end
        end
    end

    // line store: read returns the previous row's value before this write lands
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            above_rd_reg     <= row_store[c_cur];
            row_store[c_cur] <= s_data.depth_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            c_reg      <= c_cur;
            r_reg      <= r_cur;
            sample_reg <= s_data.depth_sample;
            win0_reg   <= prior_row_above_reg;
            win2_reg   <= prior_sample_reg;
        end
        if (cmd.fetch) begin
            sum_reg   <= sum_w;
            cnt_reg   <= cnt_w;
            xprod_reg <= (ADDR_W+RECIP_W)'(cc) * (ADDR_W+RECIP_W)'(rcp);
            yprod_reg <= (ROW_W+RECIP_W)'(rr) * (ROW_W+RECIP_W)'(rcp);
        end
        if (cmd.quot) begin
            x_reg   <= xprod_reg[RECIP_SHIFT +: ADDR_W];
            y_reg   <= yprod_reg[RECIP_SHIFT +: ROW_W];
            avg_reg <= avg_w;
        end
        if (cmd.load_out) begin
            out_data_reg.out_col    <= x_reg[8:0];
            out_data_reg.out_row    <= y_reg[8:0];
            out_data_reg.high_byte  <= div_quo[15:8];
            out_data_reg.low_byte   <= div_quo[7:0];
            out_data_reg.frame_done <= last_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    dhds_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (avg_reg),
        .divisor  (div_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/core/dhds_ctrl.sv @@
module dhds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dhds_pkg::dp_status_t status,
    output dhds_pkg::ctrl_cmd_t  cmd
);
    import dhds_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_QUOT;
            end
            ST_QUOT: begin
                cmd.quot   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.produce) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the result register to drain
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
